// File: hdl/ascii_sentence_deframer_defines.svh
// Assertion macros for the sentence deframer checker.
// Depends on nothing; included by the checker file.
`ifndef ASCII_SENTENCE_DEFRAMER_DEFINES_SVH
`define ASCII_SENTENCE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/asd_pkg.sv
// Shared constants, status codes and the hex digit decoder of the sentence deframer.
// Depends on nothing; used by the top level and its checker.
`default_nettype none
package asd_pkg;

	localparam int PAYLOAD_MAX    = 31;
	localparam int RX_BUFFER_SIZE = 64;

	localparam int PLEN_W = $clog2(PAYLOAD_MAX + 1);
	localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int SLEN_W = $clog2(RX_BUFFER_SIZE);

	// Output word: data, status, id, received, hex ok, computed, match, zero fill.
	localparam int OUT_W = 48;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ID   = 2'd1;
	localparam logic [1:0] ST_BAD_CSUM = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t r;
		logic [7:0] d;
		r.ok = 1'b1;
		r.value = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			r.value = d[3:0];
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			d = c - CH_UPPER_A + 8'd10;
			r.value = d[3:0];
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/asd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module asd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/ascii_sentence_deframer.sv
// Top level of the ASCII sentence deframer: framing state, payload store and output register.
// Depends on asd_pkg and asd_ram.
//
//  Channel  | Role   | Word contents
//  ---------+--------+----------------------------------------------------------
//  s_axis   | input  | tdata[7:0] received character
//  m_axis   | output | tdata payload byte or status, tuser is_status, tlast last
//
// A character that ends a sentence with an error, or a good one with no payload, loads a
// status word straight into the output register. A good sentence with N stored payload
// bytes then drains them from the payload RAM, each as a read (CTL_RD) and a load of the
// output register (CTL_WAIT), followed by the status word (CTL_STATUS); the input stays
// closed until that status word is loaded. Reset (arst_n, asynchronous) returns to hunting
// for the start character; the payload RAM is not cleared. A stall on m_axis holds the
// output word; while that word waits, s_axis stays closed and a drain pauses.
`default_nettype none
module ascii_sentence_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [asd_pkg::OUT_W-1:0] m_axis_tdata, // [7:0] data_byte, [9:8] status,
	                                         // [25:10] sentence_id,
	                                         // [33:26] received_checksum,
	                                         // [34] checksum_hex_ok,
	                                         // [42:35] computed_checksum,
	                                         // [43] checksum_match, [47:44] zero
	output logic             m_axis_tuser,   // [0] is_status
	output logic             m_axis_tlast    // last
);

	localparam int PLEN_W = asd_pkg::PLEN_W;
	localparam int ADDR_W = asd_pkg::ADDR_W;
	localparam int SLEN_W = asd_pkg::SLEN_W;

	// Position inside the sentence being framed.
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ID,
		PH_PAYLOAD,
		PH_TAIL,
		PH_TAIL_CR
	} phase_t;

	// Input side is open only in CTL_RUN; the other states drain a good sentence.
	typedef enum logic [1:0] {
		CTL_RUN,
		CTL_RD,
		CTL_WAIT,
		CTL_STATUS
	} ctl_t;

	typedef struct packed {
		logic [1:0]  count;
		logic [15:0] chars;
	} field_t;

	// Collects a character of a two-character field; the count saturates at three.
	function automatic field_t add_char(input field_t f, input logic [7:0] c);
		field_t r;
		r = f;
		if (f.count == 2'd0) begin
			r.chars[15:8] = c;
		end else if (f.count == 2'd1) begin
			r.chars[7:0] = c;
		end
		if (f.count != 2'd3) begin
			r.count = f.count + 2'd1;
		end
		return r;
	endfunction

	phase_t              phase_q, phase_d;
	ctl_t                ctl_q;
	field_t              id_q, id_d;
	field_t              tail_q, tail_d;
	logic [7:0]          xor_q, xor_d;
	logic [PLEN_W-1:0]   plen_q, plen_d;
	logic [SLEN_W-1:0]   slen_q, slen_d;
	logic [ADDR_W-1:0]   rd_idx_q;

	logic                       out_valid_q;
	logic [asd_pkg::OUT_W-1:0]  out_data_q;
	logic                       out_user_q;
	logic                       out_last_q;

	logic                slot_free;
	logic                in_fire;
	logic                ram_we;
	logic                ram_re;
	logic [7:0]          ram_rdata;
	logic                emit_err;
	logic [1:0]          err_code;
	logic                emit_ok;
	logic                start_drain;
	logic                drain_done;

	asd_pkg::hex_digit_t        hex_hi, hex_lo;
	logic                       hex_ok;
	logic [7:0]                 rx_csum;
	logic [asd_pkg::OUT_W-1:0]  ok_word;
	logic [asd_pkg::OUT_W-1:0]  err_word;

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (ctl_q == CTL_RUN) && slot_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	// Checksum decode from the held tail characters; these stay put during a drain.
	assign hex_hi  = asd_pkg::hex_decode(tail_q.chars[15:8]);
	assign hex_lo  = asd_pkg::hex_decode(tail_q.chars[7:0]);
	assign hex_ok  = hex_hi.ok && hex_lo.ok;
	assign rx_csum = hex_ok ? {hex_hi.value, hex_lo.value} : 8'd0;

	assign ok_word  = {4'd0, (hex_ok && (rx_csum == xor_q)), xor_q, hex_ok, rx_csum,
	                   id_q.chars, asd_pkg::ST_OK, 8'd0};
	assign err_word = {38'd0, err_code, 8'd0};

	assign drain_done = ((PLEN_W'(rd_idx_q) + PLEN_W'(1)) == plen_q);
	assign ram_re     = (ctl_q == CTL_RD);

	// Framing step for one accepted character.
	always_comb begin
		phase_d     = phase_q;
		id_d        = id_q;
		tail_d      = tail_q;
		xor_d       = xor_q;
		plen_d      = plen_q;
		slen_d      = slen_q;
		ram_we      = 1'b0;
		emit_err    = 1'b0;
		err_code    = asd_pkg::ST_OK;
		emit_ok     = 1'b0;
		start_drain = 1'b0;
		if (in_fire) begin
			if (phase_q == PH_HUNT) begin
				if (s_axis_tdata == asd_pkg::CH_DOLLAR) begin
					phase_d = PH_ID;
					id_d    = '0;
					tail_d  = '0;
					xor_d   = 8'd0;
					plen_d  = '0;
					slen_d  = SLEN_W'(1);
				end
			end else if (slen_q >= SLEN_W'(asd_pkg::RX_BUFFER_SIZE - 1)) begin
				// The sentence no longer fits the receive buffer.
				phase_d  = PH_HUNT;
				emit_err = 1'b1;
				err_code = asd_pkg::ST_OVERFLOW;
			end else begin
				slen_d = slen_q + SLEN_W'(1);
				case (phase_q)
					PH_ID: begin
						xor_d = xor_q ^ s_axis_tdata;
						if (s_axis_tdata == asd_pkg::CH_COMMA) begin
							phase_d = PH_PAYLOAD;
						end else begin
							id_d = add_char(id_q, s_axis_tdata);
						end
					end
					PH_PAYLOAD: begin
						if (s_axis_tdata == asd_pkg::CH_STAR) begin
							phase_d = PH_TAIL;
						end else begin
							xor_d = xor_q ^ s_axis_tdata;
							if (plen_q < PLEN_W'(asd_pkg::PAYLOAD_MAX)) begin
								ram_we = 1'b1;
								plen_d = plen_q + PLEN_W'(1);
							end
						end
					end
					PH_TAIL: begin
						if (s_axis_tdata == asd_pkg::CH_CR) begin
							phase_d = PH_TAIL_CR;
						end else begin
							tail_d = add_char(tail_q, s_axis_tdata);
						end
					end
					PH_TAIL_CR: begin
						if (s_axis_tdata == asd_pkg::CH_LF) begin
							phase_d = PH_HUNT;
							if (id_q.count != 2'd2) begin
								emit_err = 1'b1;
								err_code = asd_pkg::ST_BAD_ID;
							end else if (tail_q.count != 2'd2) begin
								emit_err = 1'b1;
								err_code = asd_pkg::ST_BAD_CSUM;
							end else if (plen_q == '0) begin
								emit_ok = 1'b1;
							end else begin
								start_drain = 1'b1;
							end
						end else begin
							// The pending CR was a checksum character after all.
							tail_d = add_char(tail_q, asd_pkg::CH_CR);
							if (s_axis_tdata != asd_pkg::CH_CR) begin
								tail_d  = add_char(add_char(tail_q, asd_pkg::CH_CR),
								                   s_axis_tdata);
								phase_d = PH_TAIL;
							end
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	asd_ram #(
		.WIDTH(8),
		.DEPTH(asd_pkg::PAYLOAD_MAX)
	) u_payload_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(plen_q[ADDR_W-1:0]),
		.wdata(s_axis_tdata),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			ctl_q       <= CTL_RUN;
			id_q        <= '0;
			tail_q      <= '0;
			xor_q       <= 8'd0;
			plen_q      <= '0;
			slen_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			id_q    <= id_d;
			tail_q  <= tail_d;
			xor_q   <= xor_d;
			plen_q  <= plen_d;
			slen_q  <= slen_d;

			case (ctl_q)
				CTL_RUN: begin
					if (emit_err) begin
						out_valid_q <= 1'b1;
						out_data_q  <= err_word;
						out_user_q  <= 1'b1;
						out_last_q  <= 1'b1;
					end else if (emit_ok) begin
						out_valid_q <= 1'b1;
						out_data_q  <= ok_word;
						out_user_q  <= 1'b1;
						out_last_q  <= 1'b1;
					end else begin
						if (m_axis_tready) begin
							out_valid_q <= 1'b0;
						end
						if (start_drain) begin
							rd_idx_q <= '0;
							ctl_q    <= CTL_RD;
						end
					end
				end
				CTL_RD: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
					ctl_q <= CTL_WAIT;
				end
				CTL_WAIT: begin
					// The RAM output holds until the next read, so a stall is harmless.
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {40'd0, ram_rdata};
						out_user_q  <= 1'b0;
						out_last_q  <= 1'b0;
						if (drain_done) begin
							ctl_q <= CTL_STATUS;
						end else begin
							rd_idx_q <= rd_idx_q + ADDR_W'(1);
							ctl_q    <= CTL_RD;
						end
					end
				end
				CTL_STATUS: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= ok_word;
						out_user_q  <= 1'b1;
						out_last_q  <= 1'b1;
						ctl_q       <= CTL_RUN;
					end
				end
				default: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
					ctl_q <= CTL_RUN;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/asd_checker.sv
// Port-level checker for the sentence deframer, bound to the top level.
// Depends on asd_pkg and ascii_sentence_deframer_defines.svh.
`default_nettype none
`include "ascii_sentence_deframer_defines.svh"
module asd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);

	`ASD_ASSERT_IMP(a_status_is_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "status word without tlast")
	`ASD_ASSERT_IMP(a_payload_clean, clk, arst_n, m_axis_tvalid && !m_axis_tuser, !m_axis_tlast && (m_axis_tdata[47:8] == 40'd0), "payload word carries status fields")
	`ASD_ASSERT_IMP(a_error_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser && (m_axis_tdata[9:8] != asd_pkg::ST_OK), (m_axis_tdata[47:10] == 38'd0) && (m_axis_tdata[7:0] == 8'd0), "error status carries checksum fields")
	`ASD_ASSERT_IMP(a_match_consistent, clk, arst_n, m_axis_tvalid && m_axis_tuser && m_axis_tdata[43], m_axis_tdata[34] && (m_axis_tdata[33:26] == m_axis_tdata[42:35]), "checksum match flag disagrees with fields")
	`ASD_ASSERT_NXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

endmodule

bind ascii_sentence_deframer asd_checker u_asd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
